// ===== hdl/lsfh_pkg.sv =====
// Shared types, codes and helpers for the LIN slave frame handler.
`timescale 1ns / 1ps

package lsfh_pkg;

    // Result kinds
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Input operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_RESPONSE_ID    = 3'd0;
    localparam logic [2:0] REG_MASTER_DATA_ID = 3'd1;
    localparam logic [2:0] REG_SLEEP_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_KEY_GUARD      = 3'd3;
    localparam logic [2:0] REG_WAKE_RETRY     = 3'd4;
    localparam logic [2:0] REG_DEAD_TIME      = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Protocol constants and register reset values
    localparam logic [7:0] SYNC_BYTE           = 8'h55;
    localparam logic [7:0] RST_RESPONSE_ID     = 8'hD8;
    localparam logic [7:0] RST_MASTER_DATA_ID  = 8'h97;
    localparam logic [9:0] RST_SLEEP_TIMEOUT   = 10'd700;
    localparam logic [9:0] RST_KEY_GUARD       = 10'd20;
    localparam logic [1:0] RST_WAKE_RETRY      = 2'd3;
    localparam logic [7:0] RST_DEAD_TIME       = 8'd150;
    localparam logic [1:0] WAKE_ATTEMPTS_MAX   = 2'd3;
    localparam logic [3:0] RESPONSE_LAST_INDEX = 4'd8;

    // One input transaction
    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic [55:0] response_payload;
        logic        key_active;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [63:0] master_frame;
        logic        wake_master;
        logic        sleeping;
        logic        last;
    } t_out_item;

    // Classified work handed from front end to back end
    typedef struct packed {
        logic [1:0]  kind;
        logic        wake;
        logic        sleeping;
        logic [7:0]  id;
        logic [63:0] data;
    } t_cmd;

    // Add with end-around carry
    function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

endpackage

// ===== hdl/lin_slave_frame_handler.sv =====
// Top level of the LIN slave frame handler.
`timescale 1ns / 1ps

// LIN slave node. Push received bus bytes (op 0) and 10 ms scan ticks (op 1)
// into the input queue; pop results from the output queue. A tick yields one
// status result, the last captured master byte yields one frame result, and
// the own response id yields nine transmit bytes ending in the inverted
// enhanced checksum. Input transactions are taken one per clock while the
// two-entry command queue has room. Ticks and frames leave one per clock
// while results are popped; a response holds the serializer for nine bytes,
// one per clock, setting the sustained response rate. Configuration writes
// are always ready and must only be issued while the block is idle.
module lin_slave_frame_handler #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  lsfh_pkg::t_in_item               i_item,
    output logic                             o_empty,
    input  logic                             i_pop,
    output lsfh_pkg::t_out_item              o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsfh_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsfh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lsfh_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd front_cmd;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd queued_cmd;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !o_full;

    lsfh_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (cmd_push),
        .o_cmd       (front_cmd)
    );

    lsfh_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (queued_cmd)
    );

    lsfh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (queued_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

endmodule

// ===== hdl/lsfh_front.sv =====
// Front end: configuration registers, byte hunt, frame capture and tick bookkeeping.
`timescale 1ns / 1ps

module lsfh_front #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  lsfh_pkg::t_in_item              i_item,
    input  logic                            i_cfg_we,
    input  logic [lsfh_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [lsfh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_cmd_valid,
    output lsfh_pkg::t_cmd                  o_cmd
);
    import lsfh_pkg::*;

    localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_ID      = 3'b010,
        PH_CAPTURE = 3'b100
    } t_phase;

    // Configuration
    logic [7:0] r_response_id;
    logic [7:0] r_master_data_id;
    logic [9:0] r_sleep_timeout;
    logic [9:0] r_key_guard;
    logic [1:0] r_wake_retry;
    logic [7:0] r_dead_time;

    // Receive and tick state
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_buf [FRAME_BYTES];
    logic [9:0]       r_idle, n_idle;
    logic             r_asleep, n_asleep;
    logic [1:0]       r_attempts, n_attempts;
    logic             r_dead, n_dead;
    logic [7:0]       r_dead_ticks, n_dead_ticks;

    logic [63:0] frame;
    logic        wake;

    // Assemble the frame from stored bytes plus the byte arriving now
    always_comb begin
        frame = '0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame[8*i +: 8] = (r_cnt[IDX_W-1:0] == IDX_W'(i)) ? i_item.rx_byte : r_buf[i];
        end
    end

    // Next-state and command classification
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_idle       = r_idle;
        n_asleep     = r_asleep;
        n_attempts   = r_attempts;
        n_dead       = r_dead;
        n_dead_ticks = r_dead_ticks;
        wake         = 1'b0;
        o_cmd_valid  = 1'b0;
        o_cmd        = '0;

        if (i_accept && i_item.op == OP_TICK) begin
            n_idle = r_idle + 10'd1;
            if (n_idle >= r_sleep_timeout) begin
                n_idle   = '0;
                n_asleep = 1'b1;
            end
            if (n_asleep) begin
                n_idle = '0;
                wake   = 1'b1;
            end
            if (n_idle >= r_key_guard && i_item.key_active) begin
                if (!r_dead) begin
                    wake = 1'b1;
                    if (r_attempts < WAKE_ATTEMPTS_MAX) begin
                        n_attempts = r_attempts + 2'd1;
                    end
                end
                if (n_attempts >= r_wake_retry) begin
                    n_dead       = 1'b1;
                    n_dead_ticks = '0;
                end
            end
            if (n_dead) begin
                n_dead_ticks = n_dead_ticks + 8'd1;
                if (n_dead_ticks >= r_dead_time) begin
                    n_dead_ticks = '0;
                    n_dead       = 1'b0;
                end
            end
            o_cmd_valid    = 1'b1;
            o_cmd.kind     = KIND_TICK;
            o_cmd.wake     = wake;
            o_cmd.sleeping = n_asleep;
        end else if (i_accept) begin
            unique case (r_phase)
                PH_ID: begin
                    if (i_item.rx_byte == r_response_id) begin
                        n_phase        = PH_HUNT;
                        o_cmd_valid    = 1'b1;
                        o_cmd.kind     = KIND_TX;
                        o_cmd.sleeping = r_asleep;
                        o_cmd.id       = r_response_id;
                        o_cmd.data     = {8'd0, i_item.response_payload};
                    end else if (i_item.rx_byte == r_master_data_id) begin
                        n_phase = PH_CAPTURE;
                        n_cnt   = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_CAPTURE: begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (n_cnt == CNT_W'(FRAME_BYTES)) begin
                        n_cnt          = '0;
                        n_phase        = PH_HUNT;
                        o_cmd_valid    = 1'b1;
                        o_cmd.kind     = KIND_FRAME;
                        o_cmd.sleeping = r_asleep;
                        o_cmd.data     = frame;
                    end
                end
                default: begin
                    if (i_item.rx_byte == SYNC_BYTE) begin
                        n_phase    = PH_ID;
                        n_idle     = '0;
                        n_asleep   = 1'b0;
                        n_attempts = '0;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_cnt        <= '0;
            r_idle       <= '0;
            r_asleep     <= 1'b0;
            r_attempts   <= '0;
            r_dead       <= 1'b0;
            r_dead_ticks <= '0;
        end else begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_idle       <= n_idle;
            r_asleep     <= n_asleep;
            r_attempts   <= n_attempts;
            r_dead       <= n_dead;
            r_dead_ticks <= n_dead_ticks;
        end
    end

    // Capture buffer
    always_ff @(posedge i_clk) begin
        if (i_accept && i_item.op == OP_BYTE && r_phase == PH_CAPTURE) begin
            r_buf[r_cnt[IDX_W-1:0]] <= i_item.rx_byte;
        end
    end

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_id    <= RST_RESPONSE_ID;
            r_master_data_id <= RST_MASTER_DATA_ID;
            r_sleep_timeout  <= RST_SLEEP_TIMEOUT;
            r_key_guard      <= RST_KEY_GUARD;
            r_wake_retry     <= RST_WAKE_RETRY;
            r_dead_time      <= RST_DEAD_TIME;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RESPONSE_ID:    r_response_id    <= i_cfg_data[7:0];
                REG_MASTER_DATA_ID: r_master_data_id <= i_cfg_data[7:0];
                REG_SLEEP_TIMEOUT:  r_sleep_timeout  <= i_cfg_data[9:0];
                REG_KEY_GUARD:      r_key_guard      <= i_cfg_data[9:0];
                REG_WAKE_RETRY:     r_wake_retry     <= i_cfg_data[1:0];
                REG_DEAD_TIME:      r_dead_time      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/lsfh_cmd_fifo.sv =====
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps

module lsfh_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsfh_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output lsfh_pkg::t_cmd o_cmd
);
    import lsfh_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/lsfh_back.sv =====
// Back end: expands commands into result transactions, serializing the response frame.
`timescale 1ns / 1ps

module lsfh_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  lsfh_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output lsfh_pkg::t_out_item o_result
);
    import lsfh_pkg::*;

    // Response serializer
    logic        r_busy;
    logic [3:0]  r_idx;
    logic [7:0]  r_sum;
    logic [55:0] r_payload;
    logic        r_sleeping;

    // Output register
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_free;
    logic      emit;
    t_out_item n_out;

    assign out_free  = !r_out_valid || i_pop;
    assign o_cmd_pop = out_free && !r_busy && !i_cmd_empty;
    assign emit      = out_free && (r_busy || !i_cmd_empty);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // Next result
    always_comb begin
        n_out          = '0;
        if (r_busy) begin
            n_out.kind     = KIND_TX;
            n_out.sleeping = r_sleeping;
            if (r_idx == RESPONSE_LAST_INDEX) begin
                n_out.tx_byte = ~r_sum;
                n_out.last    = 1'b1;
            end else begin
                n_out.tx_byte = r_payload[7:0];
            end
        end else begin
            n_out.kind     = i_cmd.kind;
            n_out.sleeping = i_cmd.sleeping;
            case (i_cmd.kind)
                KIND_FRAME: begin
                    n_out.master_frame = i_cmd.data;
                    n_out.last         = 1'b1;
                end
                KIND_TICK: begin
                    n_out.wake_master = i_cmd.wake;
                    n_out.last        = 1'b1;
                end
                default: begin
                    // leading zero byte of the response
                    n_out.tx_byte = '0;
                end
            endcase
        end
    end

    // Serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (emit) begin
            if (r_busy) begin
                if (r_idx == RESPONSE_LAST_INDEX) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 4'd1;
            end else if (i_cmd.kind == KIND_TX) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd1;
            end
        end
    end

    // Serializer data: checksum seeded with the id, payload shifted out low byte first
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (r_busy) begin
                r_sum     <= carry_add(r_sum, r_payload[7:0]);
                r_payload <= {8'd0, r_payload[55:8]};
            end else begin
                r_sum      <= i_cmd.id;
                r_payload  <= i_cmd.data[55:0];
                r_sleeping <= i_cmd.sleeping;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/lsfh_checker.sv =====
// Port-level checks for the LIN slave frame handler, bound to the top level.
`timescale 1ns / 1ps

module lsfh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_empty,
    input logic                i_pop,
    input lsfh_pkg::t_out_item i_result
);
    import lsfh_pkg::*;

    // A waiting result holds until it is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_result)))
        else $error("result changed or vanished before pop");

    // Output queue is empty right after reset
    assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> i_empty)
        else $error("result present after reset");

    // Only transmit bytes may be non-final; other kinds are valid codes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> ((i_result.kind == KIND_TX) || (i_result.kind == KIND_FRAME && i_result.last)
                      || (i_result.kind == KIND_TICK && i_result.last)))
        else $error("bad result kind or missing last flag");

    // Fields not belonging to the result kind stay zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> ((i_result.kind == KIND_TX || i_result.tx_byte == 8'd0)
                      && (i_result.kind == KIND_FRAME || i_result.master_frame == 64'd0)
                      && (i_result.kind == KIND_TICK || !i_result.wake_master)))
        else $error("field set for wrong result kind");

endmodule

bind lin_slave_frame_handler lsfh_checker u_lsfh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_empty  (o_empty),
    .i_pop    (i_pop),
    .i_result (o_result)
);
